// File: hw/rtl/sirl_pkg.sv
// ============================================================================
// sirl_pkg
// Shared definitions for the bounded set block: operation codes and the
// default sizes of the table.
// ============================================================================
package sirl_pkg;

    localparam int unsigned DEF_CAPACITY   = 16;
    localparam int unsigned DEF_VALUE_BITS = 32;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned ITEM_W   = 32;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TEST   = 2'd2
    } func_t;

endpackage

// File: hw/rtl/sirl_ram.sv
// ============================================================================
// sirl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module sirl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/set_insert_remove_lookup.sv
// ============================================================================
// set_insert_remove_lookup
// Bounded set of distinct values. Each table slot holds a valid mark and a
// value in one RAM word; every operation scans all slots once, one per cycle.
// Sequence: ST_SCAN reads every slot in turn, ST_TAIL waits for the last
//   registered read, then ST_FINISH writes back and sets done.
// A new word is taken only in ST_IDLE; busy covers the whole scan.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset: a clearing pass writes every slot invalid, with busy held high;
//   the member count resets to zero.
// ============================================================================
module set_insert_remove_lookup #(
    parameter int unsigned CAPACITY   = sirl_pkg::DEF_CAPACITY,
    parameter int unsigned VALUE_BITS = sirl_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sirl_pkg::FUNC_W-1:0]    func,
    input  logic [sirl_pkg::ITEM_W-1:0]    item_value,
    output logic                           done,
    output logic                           was_present,
    output logic [sirl_pkg::COUNT_W-1:0]   element_count,
    output logic                           add_refused
);

    import sirl_pkg::*;

    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned CW0   = $clog2(CAPACITY + 1);
    localparam int unsigned CNT_W = (CW0 > COUNT_W) ? CW0 : COUNT_W;
    localparam int unsigned WORD_W = VALUE_BITS + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   hit_reg, hit_next;
    logic [AW-1:0]          hit_idx_reg, hit_idx_next;
    logic                   free_reg, free_next;
    logic [AW-1:0]          free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   done_reg, done_next;
    logic                   present_reg, present_next;
    logic                   refused_reg, refused_next;
    logic [VALUE_BITS-1:0]  key_reg, key_next;
    logic [FUNC_W-1:0]      op_reg, op_next;

    logic [VALUE_BITS-1:0]  key_in;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;
    logic                   slot_valid;
    logic [VALUE_BITS-1:0]  slot_value;

    generate
        if (VALUE_BITS > ITEM_W)
        begin : g_key_wide
            assign key_in = {{(VALUE_BITS - ITEM_W){1'b0}}, item_value};
        end
        else if (VALUE_BITS == ITEM_W)
        begin : g_key_same
            assign key_in = item_value;
        end
        else
        begin : g_key_narrow
            assign key_in = item_value[VALUE_BITS-1:0];
        end
    endgenerate

    sirl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_valid = ram_rdata[VALUE_BITS];
    assign slot_value = ram_rdata[VALUE_BITS-1:0];
    assign ram_raddr  = idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        present_next  = present_reg;
        refused_next  = refused_reg;
        key_next      = key_reg;
        op_next       = op_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = '0;

        // compare the word returned for the previous read
        if (rd_valid_reg)
        begin
            if (slot_valid)
            begin
                if (!hit_reg && (slot_value == key_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                end
            end
            else if (!free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = rd_idx_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next      = key_in;
                    op_next       = func;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_valid_next = 1'b1;
                rd_idx_next   = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_TAIL:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                present_next = hit_reg;
                refused_next = 1'b0;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
                unique case (op_reg)
                    FUNC_ADD:
                    begin
                        if (!hit_reg)
                        begin
                            if (free_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = free_idx_reg;
                                ram_wdata  = {1'b1, key_reg};
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                refused_next = 1'b1;
                            end
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_idx_reg;
                            ram_wdata = '0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            present_reg  <= 1'b0;
            refused_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            present_reg  <= present_next;
            refused_reg  <= refused_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        key_reg      <= key_next;
        op_reg       <= op_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign was_present   = present_reg;
    assign element_count = count_reg[COUNT_W-1:0];
    assign add_refused   = refused_reg;

endmodule

// File: bench/set_insert_remove_lookup_test.sv
`timescale 1ns / 100ps
// ============================================================================
// set_insert_remove_lookup_test
// Self-checking bench for the bounded set block. Words carry an add, remove,
// membership test or spare code on a 32-bit key. A shadow table of valid marks
// and keys predicts each reply: was_present, element_count and add_refused.
// Replies are checked in order as done strobes. Directed words cover the
// empty, only element and full table cases. Random words alternate between
// fill-heavy and drain-heavy stretches over a small key pool, so the table
// fills, refuses adds and empties again.
// ============================================================================
module set_insert_remove_lookup_test;

    import sirl_pkg::*;

    localparam int          TABLE_SLOTS = DEF_CAPACITY;
    localparam int          POOL_SIZE   = 24;
    localparam int          RANDOM_OPS  = 650;
    localparam logic [1:0]  FUNC_SPARE  = 2'd3;

    typedef struct packed {
        logic                was_present;
        logic [COUNT_W-1:0]  element_count;
        logic                add_refused;
    } set_reply_t;

    class set_tracker;
        bit                 slot_used [DEF_CAPACITY];
        bit [ITEM_W-1:0]    slot_key  [DEF_CAPACITY];
        int unsigned        members;
        set_reply_t         pending [$];
        int                 errors;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            members = 0;
            errors  = 0;
        endfunction

        function void log_op(logic [1:0] op, logic [ITEM_W-1:0] key);
            int         hit;
            int         free_slot;
            set_reply_t r;
            hit       = -1;
            free_slot = -1;
            for (int i = 0; i < DEF_CAPACITY; i++)
            begin
                if (slot_used[i])
                begin
                    if (hit < 0 && slot_key[i] == key)
                        hit = i;
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            r.add_refused = 1'b0;
            if (op == FUNC_ADD)
            begin
                if (hit < 0)
                begin
                    if (free_slot >= 0)
                    begin
                        slot_used[free_slot] = 1'b1;
                        slot_key[free_slot]  = key;
                        members++;
                    end
                    else
                        r.add_refused = 1'b1;
                end
            end
            else if (op == FUNC_REMOVE && hit >= 0)
            begin
                slot_used[hit] = 1'b0;
                members--;
            end
            r.was_present   = (hit >= 0);
            r.element_count = members[COUNT_W-1:0];
            pending.push_back(r);
        endfunction

        function bit pick_member(output logic [ITEM_W-1:0] key);
            int idx [$];
            for (int i = 0; i < DEF_CAPACITY; i++)
                if (slot_used[i])
                    idx.push_back(i);
            if (idx.size() == 0)
                return 1'b0;
            key = slot_key[idx[$urandom_range(0, idx.size() - 1)]];
            return 1'b1;
        endfunction

        function void check_reply(logic wp, logic [COUNT_W-1:0] cnt, logic refused);
            set_reply_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected reply was_present=%0d element_count=%0d add_refused=%0d",
                         $time, wp, cnt, refused);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (wp !== e.was_present)
            begin
                $display("%0t: was_present expected %0d actual %0d", $time, e.was_present, wp);
                errors++;
            end
            if (cnt !== e.element_count)
            begin
                $display("%0t: element_count expected %0d actual %0d",
                         $time, e.element_count, cnt);
                errors++;
            end
            if (refused !== e.add_refused)
            begin
                $display("%0t: add_refused expected %0d actual %0d",
                         $time, e.add_refused, refused);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [FUNC_W-1:0]     func;
    logic [ITEM_W-1:0]     item_value;
    logic                  done;
    logic                  was_present;
    logic [COUNT_W-1:0]    element_count;
    logic                  add_refused;

    set_tracker            tracker;
    bit                    no_idle;
    logic [ITEM_W-1:0]     key_pool [POOL_SIZE];

    set_insert_remove_lookup u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .item_value    (item_value),
        .done          (done),
        .was_present   (was_present),
        .element_count (element_count),
        .add_refused   (add_refused)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_reply(was_present, element_count, add_refused);
    end

    task automatic issue_word(logic [1:0] op, logic [ITEM_W-1:0] key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= op;
        item_value <= key;
        do
            @(posedge clk);
        while (busy);
        tracker.log_op(op, key);
    endtask

    initial
    begin
        #3_000_000;
        $display("set_insert_remove_lookup_test: errors");
        $finish;
    end

    initial
    begin
        logic [1:0]         op;
        logic [ITEM_W-1:0]  key;
        int                 add_bias;
        int                 pick;
        bit                 got;

        tracker    = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = FUNC_TEST;
        item_value = '0;
        no_idle    = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, present add, spare code, only element removed
        issue_word(FUNC_ADD, 32'h0);
        issue_word(FUNC_ADD, 32'h0);
        issue_word(FUNC_SPARE, 32'h0);
        issue_word(FUNC_TEST, 32'h0);
        issue_word(FUNC_REMOVE, 32'h0);
        issue_word(FUNC_REMOVE, 32'h0);
        // fill to capacity, then refuse
        issue_word(FUNC_ADD, 32'hFFFF_FFFF);
        for (int i = 0; i < TABLE_SLOTS - 1; i++)
            issue_word(FUNC_ADD, 32'h1 << i);
        issue_word(FUNC_ADD, 32'h5555_5555);
        issue_word(FUNC_ADD, 32'h1);
        issue_word(FUNC_TEST, 32'hFFFF_FFFF);
        issue_word(FUNC_REMOVE, 32'hFFFF_FFFF);
        issue_word(FUNC_ADD, 32'h5555_5555);

        add_bias = 75;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 50 == 0)
                add_bias = ((n / 50) % 2) ? 25 : 75;
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < add_bias)
                op = FUNC_ADD;
            else if (pick < 90)
                op = pick[0] ? FUNC_REMOVE : FUNC_TEST;
            else if (pick < 96)
                op = FUNC_TEST;
            else
                op = FUNC_SPARE;
            got = 1'b0;
            if (op == FUNC_REMOVE && $urandom_range(0, 9) < 6)
                got = tracker.pick_member(key);
            if (!got)
            begin
                if ($urandom_range(0, 9) < 8)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    key = $urandom;
            end
            issue_word(op, key);
        end
        start <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (TABLE_SLOTS + 8) @(posedge clk);

        if (tracker.errors == 0)
            $display("set_insert_remove_lookup_test: clean");
        else
            $display("set_insert_remove_lookup_test: errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/sirl_pkg.sv
hw/rtl/sirl_ram.sv
hw/rtl/set_insert_remove_lookup.sv
bench/set_insert_remove_lookup_test.sv
